[src/mafs_pkg.sv]
// shared types, constants and tables of the mpeg audio frame splitter
`timescale 1ns / 1ps
package mafs_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 12;
  localparam int KBPS_W = 9;
  localparam int NUM_W  = 26;
  localparam int RATE_W = 16;
  localparam int QUOT_W = 12;
  localparam int STEP_W = $clog2(QUOT_W);
  localparam int DSH_W  = RATE_W + QUOT_W - 1;

  localparam logic [10:0] SYNC_WORD      = 11'h7ff;
  localparam logic [1:0]  VER_MPEG1      = 2'd3;
  localparam logic [1:0]  VER_MPEG2      = 2'd2;
  localparam logic [1:0]  VER_RESERVED   = 2'd1;
  localparam logic [1:0]  LAYER_RESERVED = 2'd0;
  localparam logic [1:0]  LAYER_CODE_III = 2'd1;
  localparam logic [1:0]  LAYER_CODE_I   = 2'd3;
  localparam logic [3:0]  BRI_FREE       = 4'h0;
  localparam logic [3:0]  BRI_BAD        = 4'hf;
  localparam logic [1:0]  SRI_RESERVED   = 2'd3;
  localparam logic [1:0]  SRI_44K        = 2'd0;
  localparam logic [1:0]  SRI_48K        = 2'd1;

  // samples per frame / 8 times 1000, layer i folded with its four-byte slot
  localparam logic [NUM_W-1:0] SCALE_L1   = NUM_W'(12000);
  localparam logic [NUM_W-1:0] SCALE_FULL = NUM_W'(144000);
  localparam logic [NUM_W-1:0] SCALE_HALF = NUM_W'(72000);

  localparam logic [LEN_W-1:0] HDR_BYTES = LEN_W'(4);

  // [low-rate family][layer i, ii, iii][bitrate index], kbit/s
  localparam logic [KBPS_W-1:0] KBPS [2][3][16] = '{
    '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
         9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
       '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
       '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
         9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} },
    '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} }
  };

  function automatic logic [RATE_W-1:0] rate_base(input logic [1:0] sri);
    logic [RATE_W-1:0] r;
    case (sri)
      SRI_44K: r = RATE_W'(44100);
      SRI_48K: r = RATE_W'(48000);
      default: r = RATE_W'(32000);
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [RATE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

[src/mafs_if.sv]
// stream interfaces for the byte input and the frame output
`timescale 1ns / 1ps
interface mafs_byte_if import mafs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mafs_frame_if import mafs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_start;
  logic              frame_end;
  logic [LEN_W-1:0]  frame_bytes;
  logic              header_error;
  logic              run_last;
  modport source (output valid, output out_byte, output frame_start, output frame_end,
                  output frame_bytes, output header_error, output run_last, input ready);
  modport sink (input valid, input out_byte, input frame_start, input frame_end,
                input frame_bytes, input header_error, input run_last, output ready);
endinterface

[src/mafs_divider.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mafs_divider import mafs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]  rem;
  logic [DSH_W-1:0]  dsh;
  logic [QUOT_W-1:0] quot;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              ge;

  assign ge = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.num;
        dsh  <= {req.den, (QUOT_W-1)'(0)};
        quot <= '0;
        step <= STEP_W'(QUOT_W-1);
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= NUM_W'(DSH_W'(rem) - dsh);
        end
        quot <= {quot[QUOT_W-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

[src/mpeg_audio_frame_splitter.sv]
// mpeg audio frame splitter: header check, frame length and byte pass-through
// body bytes: one per cycle unless output stalls, registered out the cycle after acceptance
// fourth header byte: the first header result reaches the output register after the multiply,
//   start, 12-step divider, done and load steps; three more results follow
// input is not ready while a header is in work; after a bad header all bytes are dropped
// synchronous active-high reset clears state, counters and output valid
`timescale 1ns / 1ps
module mpeg_audio_frame_splitter import mafs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mafs_byte_if.sink    byte_in,
  mafs_frame_if.source frame_out
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_EMIT,
    ST_HALT
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] header_store [3];
  logic [1:0]        header_count;
  logic [LEN_W-1:0]  bytes_left;
  logic [BYTE_W-1:0] last_byte;
  logic [KBPS_W-1:0] kbps;
  logic [NUM_W-1:0]  scale;
  logic [NUM_W-1:0]  num;
  logic [RATE_W-1:0] den;
  logic              pad;
  logic              is_l1;
  logic [LEN_W-1:0]  frame_len;
  logic [1:0]        emit_idx;

  logic              ov;
  logic [BYTE_W-1:0] o_byte;
  logic              o_start;
  logic              o_end;
  logic [LEN_W-1:0]  o_len;
  logic              o_err;
  logic              o_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        out_free;
  logic        out_load;
  logic        accept;
  logic [31:0] hdr;
  logic [1:0]  ver;
  logic [1:0]  lay;
  logic [3:0]  bri;
  logic [1:0]  sri;
  logic        hdr_ok;
  logic        low;
  logic [1:0]  shift;
  logic [1:0]  layer_idx;
  logic [LEN_W-1:0] len_calc;

  assign out_free = !ov || frame_out.ready;
  assign byte_in.ready = (state == ST_IDLE && out_free) || state == ST_HALT;
  assign accept = byte_in.valid && byte_in.ready;

  assign hdr = {header_store[0], header_store[1], header_store[2], byte_in.in_byte};
  assign ver = hdr[20:19];
  assign lay = hdr[18:17];
  assign bri = hdr[15:12];
  assign sri = hdr[11:10];
  assign hdr_ok = hdr[31:21] == SYNC_WORD && ver != VER_RESERVED && lay != LAYER_RESERVED
                  && bri != BRI_FREE && bri != BRI_BAD && sri != SRI_RESERVED;
  assign low = ver != VER_MPEG1;
  assign shift = (ver == VER_MPEG1) ? 2'd0 : ((ver == VER_MPEG2) ? 2'd1 : 2'd2);
  assign layer_idx = 2'd3 - lay;

  assign out_load = (state == ST_IDLE && accept &&
                     (bytes_left != '0 || (header_count == 2'd3 && !hdr_ok)))
                    || (state == ST_EMIT && out_free);

  assign len_calc = is_l1 ? LEN_W'((div_rsp.quot + QUOT_W'(pad)) << 2)
                          : LEN_W'(div_rsp.quot + QUOT_W'(pad));

  assign div_req.start = state == ST_START;
  assign div_req.num   = num;
  assign div_req.den   = den;

  mafs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      header_count <= '0;
      bytes_left   <= '0;
      ov           <= 1'b0;
      emit_idx     <= '0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (frame_out.ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (bytes_left != '0) begin
              o_byte     <= byte_in.in_byte;
              o_start    <= 1'b0;
              o_end      <= bytes_left == LEN_W'(1);
              o_len      <= '0;
              o_err      <= 1'b0;
              o_last     <= 1'b1;
              bytes_left <= bytes_left - LEN_W'(1);
            end else if (header_count != 2'd3) begin
              header_store[header_count] <= byte_in.in_byte;
              header_count <= header_count + 2'd1;
            end else begin
              header_count <= '0;
              if (!hdr_ok) begin
                o_byte  <= '0;
                o_start <= 1'b0;
                o_end   <= 1'b0;
                o_len   <= '0;
                o_err   <= 1'b1;
                o_last  <= 1'b1;
                state   <= ST_HALT;
              end else begin
                last_byte <= byte_in.in_byte;
                kbps      <= KBPS[low][layer_idx][bri];
                den       <= rate_base(sri) >> shift;
                pad       <= hdr[9];
                is_l1     <= lay == LAYER_CODE_I;
                if (lay == LAYER_CODE_I) begin
                  scale <= SCALE_L1;
                end else if (lay == LAYER_CODE_III && low) begin
                  scale <= SCALE_HALF;
                end else begin
                  scale <= SCALE_FULL;
                end
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          num   <= NUM_W'(kbps) * scale;
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            frame_len  <= len_calc;
            bytes_left <= len_calc - HDR_BYTES;
            emit_idx   <= '0;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_err  <= 1'b0;
            o_start <= emit_idx == 2'd0;
            o_len  <= (emit_idx == 2'd0) ? frame_len : '0;
            o_end  <= (emit_idx == 2'd3) && frame_len == HDR_BYTES;
            o_last <= emit_idx == 2'd3;
            case (emit_idx)
              2'd0:    o_byte <= header_store[0];
              2'd1:    o_byte <= header_store[1];
              2'd2:    o_byte <= header_store[2];
              default: o_byte <= last_byte;
            endcase
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_HALT: begin
          state <= ST_HALT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign frame_out.valid        = ov;
  assign frame_out.out_byte     = o_byte;
  assign frame_out.frame_start  = o_start;
  assign frame_out.frame_end    = o_end;
  assign frame_out.frame_bytes  = o_len;
  assign frame_out.header_error = o_err;
  assign frame_out.run_last     = o_last;

endmodule

[bench/mpeg_audio_frame_splitter_tb.sv]
// testbench of the mpeg audio frame splitter: random frames checked against a byte predictor
`timescale 1ns / 1ps
module mpeg_audio_frame_splitter_tb;
  import mafs_pkg::*;

  localparam logic [1:0] VER_MPEG25    = 2'd0;
  localparam logic [1:0] LAYER_CODE_II = 2'd2;
  localparam logic [1:0] SRI_32K       = 2'd2;
  localparam int         DRAIN_LIMIT   = 20000;
  localparam int         SETTLE_CYCLES = 40;

  // [low-rate family][layer i, ii, iii][bitrate index], kbit/s
  localparam int unsigned KBIT_RATE [2][3][16] = '{
    '{ '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
       '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
       '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0} },
    '{ '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0} }
  };

  typedef enum int {
    BAD_SYNC, BAD_VER, BAD_LAYER, BAD_BRI_FREE, BAD_BRI_MAX, BAD_SRI
  } bad_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_start;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_bytes;
    logic              header_error;
    logic              run_last;
  } frame_beat_t;

  class frame_scoreboard;
    frame_beat_t       beats_due[$];
    logic [BYTE_W-1:0] held [3];
    int unsigned       held_cnt;
    int unsigned       body_left;
    int unsigned       fails;
    bit                locked_out;

    function new();
      held_cnt   = 0;
      body_left  = 0;
      fails      = 0;
      locked_out = 1'b0;
      foreach (held[i]) held[i] = '0;
    endfunction

    // frame length in bytes, zero for a header that fails the checks
    function int unsigned frame_len(logic [31:0] w);
      logic [1:0]  ver;
      logic [1:0]  lay;
      logic [1:0]  sri;
      logic [3:0]  bri;
      int unsigned shift;
      int unsigned low;
      int unsigned layer_idx;
      int unsigned sr;
      int unsigned br;
      int unsigned spf;
      ver = w[20:19];
      lay = w[18:17];
      bri = w[15:12];
      sri = w[11:10];
      if (w[31:21] != SYNC_WORD || ver == VER_RESERVED || lay == LAYER_RESERVED ||
          bri == BRI_FREE || bri == BRI_BAD || sri == SRI_RESERVED)
        return 0;
      shift = (ver == VER_MPEG1) ? 0 : ((ver == VER_MPEG2) ? 1 : 2);
      low = (shift > 0) ? 1 : 0;
      layer_idx = 3 - int'(lay);
      case (sri)
        SRI_44K: sr = 44100;
        SRI_48K: sr = 48000;
        default: sr = 32000;
      endcase
      sr = sr >> shift;
      br = KBIT_RATE[low][layer_idx][bri] * 1000;
      if (layer_idx == 0)
        return (384 * br / (32 * sr) + int'(w[9])) * 4;
      spf = (layer_idx == 2 && low == 1) ? 576 : 1152;
      return spf * br / (8 * sr) + int'(w[9]);
    endfunction

    function void add_beat(logic [BYTE_W-1:0] b, logic fs, logic fe, logic [LEN_W-1:0] len,
                           logic err, logic last);
      frame_beat_t e;
      e.out_byte     = b;
      e.frame_start  = fs;
      e.frame_end    = fe;
      e.frame_bytes  = len;
      e.header_error = err;
      e.run_last     = last;
      beats_due.push_back(e);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      logic [31:0] word;
      int unsigned len;
      int unsigned rest;
      if (locked_out)
        return;
      if (body_left != 0) begin
        add_beat(b, 1'b0, body_left == 1, '0, 1'b0, 1'b1);
        body_left--;
        return;
      end
      if (held_cnt < 3) begin
        held[held_cnt] = b;
        held_cnt++;
        return;
      end
      held_cnt = 0;
      word = {held[0], held[1], held[2], b};
      len = frame_len(word);
      if (len == 0) begin
        locked_out = 1'b1;
        add_beat('0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
        return;
      end
      rest = (len >= 4) ? len - 4 : 0;
      add_beat(held[0], 1'b1, 1'b0, LEN_W'(len), 1'b0, 1'b0);
      add_beat(held[1], 1'b0, 1'b0, '0, 1'b0, 1'b0);
      add_beat(held[2], 1'b0, 1'b0, '0, 1'b0, 1'b0);
      add_beat(b, 1'b0, rest == 0, '0, 1'b0, 1'b1);
      body_left = rest;
    endfunction

    function void compare(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        fails++;
      end
    endfunction

    function void check_beat(frame_beat_t got);
      frame_beat_t exp;
      if (beats_due.size() == 0) begin
        $error("unexpected transaction: out_byte %0d, header_error %0d",
               got.out_byte, got.header_error);
        fails++;
        return;
      end
      exp = beats_due.pop_front();
      compare("out_byte", exp.out_byte, got.out_byte);
      compare("frame_start", exp.frame_start, got.frame_start);
      compare("frame_end", exp.frame_end, got.frame_end);
      compare("frame_bytes", exp.frame_bytes, got.frame_bytes);
      compare("header_error", exp.header_error, got.header_error);
      compare("run_last", exp.run_last, got.run_last);
    endfunction

    function int unsigned pending();
      return beats_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   sent_bytes;

  frame_scoreboard board = new();

  mafs_byte_if  in_if ();
  mafs_frame_if out_if ();

  mpeg_audio_frame_splitter u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (in_if),
    .frame_out (out_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] make_header(logic [1:0] ver, logic [1:0] lay, logic [3:0] bri,
                                              logic [1:0] sri, logic pad);
    return {SYNC_WORD, ver, lay, 1'($urandom), bri, sri, pad, 9'($urandom)};
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    board.note_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [1:0] ver, input logic [1:0] lay, input logic [3:0] bri,
                            input logic [1:0] sri, input logic pad, input bit patterned);
    logic [31:0] hdr;
    int unsigned len;
    hdr = make_header(ver, lay, bri, sri, pad);
    len = board.frame_len(hdr);
    for (int i = 0; i < 4; i++)
      send_byte(hdr[31 - 8 * i -: 8]);
    for (int unsigned i = 0; i + 4 < len; i++) begin
      if (patterned && i < 2)
        send_byte({BYTE_W{i[0]}});
      else
        send_byte(BYTE_W'($urandom));
    end
  endtask

  always @(posedge clk) begin : watch_out
    frame_beat_t seen;
    if (!rst && out_if.valid && out_if.ready) begin
      seen.out_byte     = out_if.out_byte;
      seen.frame_start  = out_if.frame_start;
      seen.frame_end    = out_if.frame_end;
      seen.frame_bytes  = out_if.frame_bytes;
      seen.header_error = out_if.header_error;
      seen.run_last     = out_if.run_last;
      board.check_beat(seen);
    end
  end

  initial begin : out_stall
    int gap;
    out_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] bad_hdr;
    bad_kind_t   bad_kind;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    int          r;
    int          rand_frames;
    int          rand_start;
    int          drain;
    rst           = 1'b1;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    calm          = 1'b0;
    sent_bytes    = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // short frames covering each version and each layer, both paddings
    calm = 1'b1;
    send_frame(VER_MPEG1, LAYER_CODE_I, 4'd1, SRI_48K, 1'b0, 1'b1);
    calm = 1'b0;
    send_frame(VER_MPEG2, LAYER_CODE_III, 4'd1, SRI_32K, 1'b1, 1'b0);
    send_frame(VER_MPEG25, LAYER_CODE_III, 4'd1, SRI_48K, 1'b0, 1'b0);
    send_frame(VER_MPEG2, LAYER_CODE_II, 4'd1, SRI_48K, 1'b0, 1'b0);
    send_frame(VER_MPEG1, LAYER_CODE_III, 4'd1, SRI_48K, 1'b1, 1'b0);

    // well-formed short frames
    rand_frames = 0;
    rand_start  = sent_bytes;
    while (sent_bytes - rand_start < 30 || rand_frames < 1) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 1);
      if (r == 1) begin
        ver = VER_MPEG1;
        lay = LAYER_CODE_I;
      end else begin
        ver = VER_MPEG2;
        lay = LAYER_CODE_III;
      end
      bri = 4'($urandom_range(1, 2));
      send_frame(ver, lay, bri, 2'($urandom_range(0, 2)), 1'($urandom), 1'b0);
      rand_frames++;
    end

    // one broken header locks the block out until reset, so it comes last
    calm = 1'b0;
    bad_hdr = make_header(VER_MPEG1, LAYER_CODE_I, 4'($urandom_range(1, 14)),
                          2'($urandom_range(0, 2)), 1'($urandom));
    bad_kind = bad_kind_t'($urandom_range(0, 5));
    case (bad_kind)
      BAD_SYNC:     bad_hdr[21 + $urandom_range(0, 10)] = 1'b0;
      BAD_VER:      bad_hdr[20:19] = VER_RESERVED;
      BAD_LAYER:    bad_hdr[18:17] = LAYER_RESERVED;
      BAD_BRI_FREE: bad_hdr[15:12] = BRI_FREE;
      BAD_BRI_MAX:  bad_hdr[15:12] = BRI_BAD;
      default:      bad_hdr[11:10] = SRI_RESERVED;
    endcase
    for (int i = 0; i < 4; i++)
      send_byte(bad_hdr[31 - 8 * i -: 8]);
    // dropped after the error
    repeat (20) send_byte(BYTE_W'($urandom));
    in_if.valid <= 1'b0;

    for (drain = 0; drain < DRAIN_LIMIT && board.pending() != 0; drain++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d transactions still expected at the end", board.pending());
      board.fails++;
    end

    if (board.fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
